/* rtl/psrnq_pkg.sv */
// Package for the point store with radius count and nearest search.
// Holds beat types, command and status codes and parameter defaults.
// No dependencies.
package psrnq_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int COORD_BITS_DEF = 24;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_QUERY  = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_SLOT = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         slot;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic [22:0]        reach;
    } cmd_beat_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] new_index;
        logic [8:0] hit_count;
        logic       any_hit;
        logic       nearest_valid;
        logic [7:0] nearest_index;
    } res_beat_t;

endpackage

/* rtl/point_store_radius_nearest_query_top.sv */
// Top level of the point store with radius count and nearest search.
// Holds the point memory, the bit-serial squaring engine and the control FSM.
// Depends on psrnq_pkg.

// Stores up to CAPACITY 3D points (signed Q12.12, low COORD_BITS bits of each
// coordinate taken and sign-extended) and answers one command beat with one
// result beat. Insert, update and clear pass through the execute and done
// states. A query first squares the radius, then walks the stored points one
// at a time: each point is read from the point memory's registered read port,
// its three absolute coordinate differences are formed, and the squared
// distance is built by one shared shift-and-add unit that consumes one
// multiplier bit per cycle from an MW = max(COORD_BITS, 23) bit multiplier;
// that serial squaring unit sets the query time. A new command beat is taken
// only while the FSM is idle; a finished result waits in the done state while
// the output register still holds an unaccepted result, blocking new commands.
// Distances are exact; ties go to the lowest index; hit_count saturates at 511.
module point_store_radius_nearest_query_top
    import psrnq_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_beat_t cmd_beat,
    output logic      res_valid,
    input  logic      res_stall,
    output res_beat_t res_beat
);

    localparam int CB  = COORD_BITS;
    localparam int IW  = $clog2(CAPACITY);
    localparam int TW  = $clog2(CAPACITY + 1);
    localparam int AW  = (IW > 8) ? IW : 8;
    localparam int CW  = (AW + 1 > TW) ? AW + 1 : TW;
    localparam int HW  = (TW > 10) ? TW : 10;
    localparam int MW  = (CB > 23) ? CB : 23;
    localparam int SW  = 2 * MW + 2;
    localparam int NW  = $clog2(MW);
    localparam int PW  = 3 * CB;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_DIFF = 3'd4;
    localparam logic [2:0] S_CMP  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam logic [1:0] T_RSQ = 2'd0;
    localparam logic [1:0] T_X   = 2'd1;
    localparam logic [1:0] T_Y   = 2'd2;
    localparam logic [1:0] T_Z   = 2'd3;

    // control state
    logic [2:0]    state_reg, state_next;
    logic [TW-1:0] total_reg, total_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [TW-1:0] count_reg, count_next;
    logic [1:0]    term_reg, term_next;
    logic [NW-1:0] bit_reg, bit_next;
    logic          res_valid_reg, res_valid_next;

    // payload state
    cmd_beat_t     beat_reg, beat_next;
    res_beat_t     res_reg, res_next;
    res_beat_t     out_reg, out_next;
    logic [SW-1:0] acc_reg, acc_next;
    logic [SW-1:0] mcand_reg, mcand_next;
    logic [MW-1:0] mplier_reg, mplier_next;
    logic [SW-1:0] rsq_reg, rsq_next;
    logic [SW-1:0] best_reg, best_next;
    logic [IW-1:0] nidx_reg, nidx_next;
    logic [CB-1:0] dy_reg, dy_next;
    logic [CB-1:0] dz_reg, dz_next;

    // point memory: {x, y, z} per entry
    logic [PW-1:0] mem [CAPACITY];
    logic [PW-1:0] rd_data_reg;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [PW-1:0] mem_wd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[idx_reg];
    end

    // coordinates of the current beat, cut or sign-extended to CB bits
    logic signed [CB-1:0] in_x, in_y, in_z;
    assign in_x = CB'(beat_reg.pos_x);
    assign in_y = CB'(beat_reg.pos_y);
    assign in_z = CB'(beat_reg.pos_z);

    function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
        logic signed [CB:0] d;
        logic signed [CB:0] m;
        d = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
        m = d[CB] ? -d : d;
        return m[CB-1:0];
    endfunction

    logic [CB-1:0] dx_w, dy_w, dz_w;
    assign dx_w = abs_diff(rd_data_reg[PW-1:2*CB], in_x);
    assign dy_w = abs_diff(rd_data_reg[2*CB-1:CB], in_y);
    assign dz_w = abs_diff(rd_data_reg[CB-1:0], in_z);

    logic [AW-1:0] slot_ext;
    assign slot_ext = AW'(beat_reg.slot);

    logic [SW-1:0] acc_sum;
    assign acc_sum = acc_reg + (mplier_reg[0] ? mcand_reg : '0);

    logic [HW-1:0] count_ext;
    logic [AW-1:0] nidx_ext;
    logic [AW-1:0] total_idx_ext;
    assign count_ext     = HW'(count_reg);
    assign nidx_ext      = AW'(nidx_reg);
    assign total_idx_ext = AW'(total_reg);

    logic last_point;
    assign last_point = (TW'(idx_reg) == total_reg - TW'(1));

    logic out_free;
    assign out_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        term_next      = term_reg;
        bit_next       = bit_reg;
        beat_next      = beat_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        rsq_next       = rsq_reg;
        best_next      = best_reg;
        nidx_next      = nidx_reg;
        dy_next        = dy_reg;
        dz_next        = dz_reg;
        mem_we         = 1'b0;
        mem_wa         = total_reg[IW-1:0];
        mem_wd         = {in_x, in_y, in_z};
        res_valid_next = res_valid_reg;

        // drop the result once the far side takes it
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    beat_next  = cmd_beat;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_next   = '0;
                state_next = S_DONE;
                unique case (beat_reg.cmd)
                    CMD_INSERT:
                    begin
                        if (total_reg >= TW'(CAPACITY))
                        begin
                            res_next.status = STAT_FULL;
                        end
                        else
                        begin
                            mem_we             = 1'b1;
                            res_next.new_index = total_idx_ext[7:0];
                            total_next         = total_reg + TW'(1);
                        end
                    end
                    CMD_UPDATE:
                    begin
                        if (CW'(beat_reg.slot) >= CW'(total_reg))
                        begin
                            res_next.status = STAT_BAD_SLOT;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            mem_wa = slot_ext[IW-1:0];
                        end
                    end
                    CMD_CLEAR:
                    begin
                        total_next = '0;
                    end
                    default:
                    begin
                        // query: square the radius first
                        acc_next    = '0;
                        mcand_next  = SW'(beat_reg.reach);
                        mplier_next = MW'(beat_reg.reach);
                        bit_next    = NW'(MW - 1);
                        term_next   = T_RSQ;
                        idx_next    = '0;
                        count_next  = '0;
                        nidx_next   = '0;
                        state_next  = S_MUL;
                    end
                endcase
            end
            S_MUL:
            begin
                acc_next    = acc_sum;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                bit_next    = bit_reg - NW'(1);
                if (bit_reg == '0)
                begin
                    bit_next = NW'(MW - 1);
                    unique case (term_reg)
                        T_RSQ:
                        begin
                            rsq_next   = acc_sum;
                            state_next = (total_reg == '0) ? S_DONE : S_RD;
                        end
                        T_X:
                        begin
                            mcand_next  = SW'(dy_reg);
                            mplier_next = MW'(dy_reg);
                            term_next   = T_Y;
                        end
                        T_Y:
                        begin
                            mcand_next  = SW'(dz_reg);
                            mplier_next = MW'(dz_reg);
                            term_next   = T_Z;
                        end
                        default:
                        begin
                            state_next = S_CMP;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                acc_next    = '0;
                mcand_next  = SW'(dx_w);
                mplier_next = MW'(dx_w);
                dy_next     = dy_w;
                dz_next     = dz_w;
                bit_next    = NW'(MW - 1);
                term_next   = T_X;
                state_next  = S_MUL;
            end
            S_CMP:
            begin
                if (beat_reg.reach != '0 && acc_reg <= rsq_reg)
                begin
                    count_next = count_reg + TW'(1);
                end
                if (idx_reg == '0 || acc_reg < best_reg)
                begin
                    best_next = acc_reg;
                    nidx_next = idx_reg;
                end
                if (last_point)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_RD;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next = res_reg;
                    if (beat_reg.cmd == CMD_QUERY)
                    begin
                        out_next.hit_count     = (count_ext > HW'(511)) ? 9'd511
                                                                        : count_ext[8:0];
                        out_next.any_hit       = (count_reg != '0);
                        out_next.nearest_valid = (total_reg != '0);
                        out_next.nearest_index = (total_reg != '0) ? nidx_ext[7:0] : 8'd0;
                    end
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            idx_reg       <= '0;
            count_reg     <= '0;
            term_reg      <= T_RSQ;
            bit_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            term_reg      <= term_next;
            bit_reg       <= bit_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg   <= beat_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rsq_reg    <= rsq_next;
        best_reg   <= best_next;
        nidx_reg   <= nidx_next;
        dy_reg     <= dy_next;
        dz_reg     <= dz_next;
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res_beat  = out_reg;

endmodule

/* verif/point_store_radius_nearest_query_top_test.sv */
// Self-checking testbench for point_store_radius_nearest_query_top.
// Drives command beats from a queue, predicts each result beat with a local point store model.
// Depends on psrnq_pkg and the RTL top level.
module point_store_radius_nearest_query_top_test;
    import psrnq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 256;
    localparam longint CYCLE_LIMIT = 64'd40_000_000;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    cmd_beat_t cmd_beat;
    logic      res_valid;
    logic      res_stall;
    res_beat_t res_beat;

    point_store_radius_nearest_query_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_beat  (cmd_beat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat)
    );

    // Shadow of the point memory; only entries below shadow_total are ever read.
    logic signed [23:0] shadow_x [CAP];
    logic signed [23:0] shadow_y [CAP];
    logic signed [23:0] shadow_z [CAP];
    int                 shadow_total;

    cmd_beat_t pending_cmds [$];
    res_beat_t expected_results [$];

    int     send_idle_pct;
    int     recv_idle_pct;
    bit     failed;
    longint cycle_count;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Append a command beat to the tail of the pending queue.
    function automatic void queue_cmd(cmd_beat_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    // Append a predicted result beat to the tail of the expected queue.
    function automatic void queue_expected(res_beat_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    // Exact squared distance; 3 * (2^24)^2 fits easily in 64 bits.
    function automatic longint unsigned dist_sq(int idx, logic signed [23:0] ox,
                                                logic signed [23:0] oy,
                                                logic signed [23:0] oz);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'(shadow_x[idx]) - longint'(ox);
        dy = longint'(shadow_y[idx]) - longint'(oy);
        dz = longint'(shadow_z[idx]) - longint'(oz);
        return longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
    endfunction

    // Apply one command to the shadow store and return the result it should produce.
    function automatic res_beat_t apply_command(cmd_beat_t c);
        res_beat_t      r;
        longint unsigned d;
        longint unsigned best;
        longint unsigned rsq;
        int             hits;
        r = '0;
        best = '0;
        hits = 0;
        case (c.cmd)
            CMD_INSERT:
            begin
                if (shadow_total >= CAP)
                    r.status = STAT_FULL;
                else
                begin
                    shadow_x[shadow_total] = c.pos_x;
                    shadow_y[shadow_total] = c.pos_y;
                    shadow_z[shadow_total] = c.pos_z;
                    r.new_index = shadow_total[7:0];
                    shadow_total++;
                end
            end
            CMD_UPDATE:
            begin
                if (int'(c.slot) >= shadow_total)
                    r.status = STAT_BAD_SLOT;
                else
                begin
                    shadow_x[c.slot] = c.pos_x;
                    shadow_y[c.slot] = c.pos_y;
                    shadow_z[c.slot] = c.pos_z;
                end
            end
            CMD_CLEAR:
                shadow_total = 0;
            default:
            begin
                rsq = longint'(c.reach) * longint'(c.reach);
                for (int i = 0; i < shadow_total; i++)
                begin
                    d = dist_sq(i, c.pos_x, c.pos_y, c.pos_z);
                    if (c.reach != 0 && d <= rsq)
                        hits++;
                    if (i == 0 || d < best)
                    begin
                        best = d;
                        r.nearest_index = i[7:0];
                    end
                end
                r.nearest_valid = (shadow_total > 0);
                r.hit_count = (hits > 511) ? 9'd511 : hits[8:0];
                r.any_hit = (hits > 0);
            end
        endcase
        return r;
    endfunction

    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'(int'($urandom_range(0, 8191)) - 4096);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic cmd_beat_t make_cmd(logic [1:0] op);
        cmd_beat_t c;
        c.cmd   = op;
        c.slot  = 8'($urandom);
        c.pos_x = rand_coord();
        c.pos_y = rand_coord();
        c.pos_z = rand_coord();
        c.reach = 23'($urandom);
        return c;
    endfunction

    // Clustered points keep radius queries hitting and make ties happen.
    function automatic cmd_beat_t make_cluster_cmd(logic [1:0] op);
        cmd_beat_t c;
        c = make_cmd(op);
        c.pos_x = 24'(int'($urandom_range(0, 63)) - 32);
        c.pos_y = 24'(int'($urandom_range(0, 63)) - 32);
        c.pos_z = 24'(int'($urandom_range(0, 3)));
        c.reach = ($urandom_range(0, 3) == 0) ? 23'd0 : 23'($urandom_range(0, 60));
        if ($urandom_range(0, 1) == 1)
            c.slot = 8'($urandom_range(0, 20));
        return c;
    endfunction

    // Driver: present the queue head, advance only on an accepted beat.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd_beat  <= '0;
        end
        else if (!cmd_valid || !cmd_stall)
        begin
            // Previous beat (if any) was taken; pop it and consider the next one.
            if (cmd_valid)
            begin
                queue_expected(apply_command(pending_cmds.pop_front()));
            end
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                cmd_valid <= 1'b1;
                cmd_beat  <= pending_cmds[0];
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // Monitor: check each accepted result beat against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected: %p", res_beat);
                    failed = 1'b1;
                end
                else
                begin
                    res_beat_t e;
                    e = expected_results.pop_front();
                    if (res_beat.status !== e.status)
                    begin
                        $error("status exp %0d got %0d", e.status, res_beat.status);
                        failed = 1'b1;
                    end
                    if (res_beat.new_index !== e.new_index)
                    begin
                        $error("new_index exp %0d got %0d", e.new_index, res_beat.new_index);
                        failed = 1'b1;
                    end
                    if (res_beat.hit_count !== e.hit_count)
                    begin
                        $error("hit_count exp %0d got %0d", e.hit_count, res_beat.hit_count);
                        failed = 1'b1;
                    end
                    if (res_beat.any_hit !== e.any_hit)
                    begin
                        $error("any_hit exp %0d got %0d", e.any_hit, res_beat.any_hit);
                        failed = 1'b1;
                    end
                    if (res_beat.nearest_valid !== e.nearest_valid)
                    begin
                        $error("nearest_valid exp %0d got %0d", e.nearest_valid,
                               res_beat.nearest_valid);
                        failed = 1'b1;
                    end
                    if (res_beat.nearest_index !== e.nearest_index)
                    begin
                        $error("nearest_index exp %0d got %0d", e.nearest_index,
                               res_beat.nearest_index);
                        failed = 1'b1;
                    end
                end
            end
            res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic run_random(int n);
        cmd_beat_t c;
        int        pick;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            // Mostly fill with clustered points and query them; keep stores small.
            if (pick < 40)
                c = make_cluster_cmd(CMD_INSERT);
            else if (pick < 52)
                c = make_cluster_cmd(CMD_UPDATE);
            else if (pick < 55)
                c = make_cmd(CMD_CLEAR);
            else if (pick < 85)
                c = make_cluster_cmd(CMD_QUERY);
            else
                c = make_cmd(2'($urandom_range(0, 3)));
            queue_cmd(c);
        end
    endtask

    // Hold until every beat is sent and answered.
    task automatic drain();
        while (pending_cmds.size() > 0 || cmd_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        cmd_beat_t c;
        failed       = 1'b0;
        cycle_count  = 0;
        shadow_total = 0;
        send_idle_pct = 28;
        recv_idle_pct = 83;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd_beat  = '0;
        res_stall = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty-store query, bad update, extreme points, tie, zero radius.
        c = make_cmd(CMD_QUERY);
        queue_cmd(c);
        c = make_cmd(CMD_UPDATE); c.slot = 8'd0;
        queue_cmd(c);
        c = '0; c.cmd = CMD_INSERT; c.pos_x = 24'sh7FFFFF; c.pos_y = 24'sh7FFFFF;
        c.pos_z = 24'sh7FFFFF;
        queue_cmd(c);
        c = '0; c.cmd = CMD_INSERT; c.pos_x = 24'sh800000; c.pos_y = 24'sh800000;
        c.pos_z = 24'sh800000;
        queue_cmd(c);
        c = '0; c.cmd = CMD_INSERT; c.pos_x = 24'sh800000; c.pos_y = 24'sh800000;
        c.pos_z = 24'sh800000;
        queue_cmd(c);
        c = '0; c.cmd = CMD_QUERY; c.pos_x = 24'sh800000; c.pos_y = 24'sh800000;
        c.pos_z = 24'sh800000; c.reach = 23'h7FFFFF;
        queue_cmd(c);
        c.reach = 23'd0;
        queue_cmd(c);
        c = '0; c.cmd = CMD_QUERY; c.reach = 23'h7FFFFF;
        queue_cmd(c);
        c = make_cmd(CMD_UPDATE); c.slot = 8'd1;
        queue_cmd(c);
        c = make_cmd(CMD_UPDATE); c.slot = 8'd3;
        queue_cmd(c);
        c = make_cmd(CMD_UPDATE); c.slot = 8'hFF;
        queue_cmd(c);
        c = make_cmd(CMD_QUERY);
        queue_cmd(c);
        queue_cmd(make_cmd(CMD_CLEAR));
        queue_cmd(make_cmd(CMD_QUERY));

        // Fill to capacity with a cluster, overflow, query the full store.
        for (int k = 0; k < CAP + 2; k++)
        begin
            c = make_cluster_cmd(CMD_INSERT);
            queue_cmd(c);
        end
        c = make_cluster_cmd(CMD_QUERY); c.reach = 23'h7FFFFF;
        queue_cmd(c);
        c = make_cluster_cmd(CMD_UPDATE); c.slot = 8'hFF;
        queue_cmd(c);
        queue_cmd(make_cluster_cmd(CMD_QUERY));
        queue_cmd(make_cmd(CMD_CLEAR));
        drain();

        run_random(600);
        drain();
        send_idle_pct = 83;
        recv_idle_pct = 28;
        queue_cmd(make_cmd(CMD_CLEAR));
        run_random(600);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_cmd(make_cmd(CMD_CLEAR));
        run_random(350);
        drain();

        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
rtl/psrnq_pkg.sv
rtl/point_store_radius_nearest_query_top.sv
verif/point_store_radius_nearest_query_top_test.sv
